### src/csjq_pkg.sv
package csjq_pkg;

  localparam int DEPTH        = 16;
  localparam int SESSION_BITS = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_INCR  = 3'd0,
    OP_PUSH_FINAL = 3'd1,
    OP_PUSH_MODEL = 3'd2,
    OP_CANCEL     = 3'd3,
    OP_POP        = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    JOB_INCR  = 2'd0,
    JOB_FINAL = 2'd1,
    JOB_MODEL = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_SUPPRESSED = 2'd1,
    ST_FULL       = 2'd2,
    ST_POP_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SESSION_BITS-1:0] session;
    logic [PAYLOAD_BITS-1:0] payload;
  } job_t;

  // Broadcast control shared by every slot of the row.
  typedef struct packed {
    logic                    remove_en;
    logic                    mask_incr;
    logic                    mask_final;
    logic                    pop_en;
    logic [SESSION_BITS-1:0] session;
  } slot_ctrl_t;

endpackage

### src/csjq_cell.sv
module csjq_cell
  import csjq_pkg::*;
(
  input  logic       clk,
  input  slot_ctrl_t ctrl,
  input  logic       live,
  input  logic       load,
  input  job_t       new_job,
  input  job_t       nb_job,
  input  logic       gap_in,
  output logic       gap_out,
  output logic       hit_incr,
  output logic       hit_final,
  output job_t       job_q
);

  job_t job_r;
  job_t job_nxt;
  logic same_session;
  logic shift;

  assign same_session = live && (job_r.session == ctrl.session);
  assign hit_incr     = same_session && (job_r.kind == JOB_INCR);
  assign hit_final    = same_session && (job_r.kind == JOB_FINAL);

  // Once a removed slot has been seen below, every slot above moves down one.
  assign gap_out = gap_in ||
                   (ctrl.remove_en && ((hit_incr && ctrl.mask_incr) ||
                                       (hit_final && ctrl.mask_final)));
  assign shift   = ctrl.pop_en || (ctrl.remove_en && gap_out);

  always_comb begin
    job_nxt = job_r;
    if (load) begin
      job_nxt = new_job;
    end else if (shift) begin
      job_nxt = nb_job;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_q = job_r;

endmodule

### src/coalescing_session_job_queue.sv
// The result of an accepted request is registered, so it is offered on the
// output the cycle after acceptance.
// Throughput: one request per cycle; the row of slots compacts, appends and
// pops in a single step. A waiting result holds in_tready low, and the next
// request is taken in the cycle that result leaves. Reset (rst_n low,
// synchronous) empties the queue and clears the output valid; slots keep data.
module coalescing_session_job_queue
  import csjq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // session[15:0], payload[47:16]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pop_valid[0], pop_kind[2:1], pop_session[18:3],
                                  // pop_payload[50:19], count[55:51], is_empty[56]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic                    accept;
  logic [2:0]              op;
  logic [SESSION_BITS-1:0] in_session;
  logic [PAYLOAD_BITS-1:0] in_payload;

  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] load_idx;
  logic [CNT_W-1:0] occ_left;

  slot_ctrl_t ctrl;
  job_t       new_job;
  logic       do_load;
  logic       freed;
  status_t    status;
  logic       pop_hit;

  logic [DEPTH-1:0] hit_incr, hit_final, load_vec, live_vec;
  logic [DEPTH:0]   gap;
  job_t             job_q [DEPTH];
  job_t             nb_job [DEPTH];
  logic             any_incr, any_final;

  logic             out_valid_r;
  status_t          status_r;
  logic             pop_valid_r;
  logic [1:0]       pop_kind_r;
  logic [15:0]      pop_session_r;
  logic [31:0]      pop_payload_r;
  logic [CNT_W-1:0] count_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign op         = in_tuser;
  assign in_session = in_tdata[15:0];
  assign in_payload = in_tdata[47:16];

  assign any_incr  = |hit_incr;
  assign any_final = |hit_final;

  assign gap[0]          = 1'b0;

  // At most one incremental or final job per session is queued, so at most
  // one slot is freed by any removal.
  assign freed    = (op == OP_PUSH_INCR) ? any_incr :
                    (((op == OP_PUSH_FINAL) || (op == OP_CANCEL)) &&
                     (any_incr || any_final));
  assign occ_left = occ_r - {{(CNT_W-1){1'b0}}, freed};

  always_comb begin
    ctrl.remove_en  = 1'b0;
    ctrl.mask_incr  = 1'b0;
    ctrl.mask_final = 1'b0;
    ctrl.pop_en     = 1'b0;
    ctrl.session    = in_session;
    new_job.kind    = JOB_INCR;
    new_job.session = in_session;
    new_job.payload = in_payload;
    do_load         = 1'b0;
    status          = ST_DONE;
    pop_hit         = 1'b0;
    occ_nxt         = occ_r;
    unique case (op)
      OP_PUSH_INCR: begin
        new_job.kind = JOB_INCR;
        if (any_final) begin
          status = ST_SUPPRESSED;
        end else begin
          if (occ_left >= CNT_W'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            ctrl.remove_en = accept;
            ctrl.mask_incr = 1'b1;
            do_load        = accept;
          end
        end
      end
      OP_PUSH_FINAL: begin
        new_job.kind = JOB_FINAL;
        if (occ_left >= CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          ctrl.remove_en  = accept;
          ctrl.mask_incr  = 1'b1;
          ctrl.mask_final = 1'b1;
          do_load         = accept;
        end
      end
      OP_PUSH_MODEL: begin
        new_job.kind = JOB_MODEL;
        if (occ_r >= CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          do_load = accept;
        end
      end
      OP_CANCEL: begin
        ctrl.remove_en  = accept;
        ctrl.mask_incr  = 1'b1;
        ctrl.mask_final = 1'b1;
        occ_nxt         = occ_left;
      end
      OP_POP: begin
        if (occ_r == '0) begin
          status = ST_POP_EMPTY;
        end else begin
          pop_hit     = 1'b1;
          ctrl.pop_en = accept;
          occ_nxt     = occ_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (do_load) begin
      occ_nxt = occ_left + CNT_W'(1);
    end
  end

  assign load_idx = occ_left;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign live_vec[i] = occ_r > CNT_W'(i);
    assign load_vec[i] = do_load && (load_idx == CNT_W'(i));
    if (i == DEPTH - 1) begin : g_top
      assign nb_job[i] = '0;
    end else begin : g_mid
      assign nb_job[i] = job_q[i+1];
    end
    csjq_cell u_slot (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (live_vec[i]),
      .load      (load_vec[i]),
      .new_job   (new_job),
      .nb_job    (nb_job[i]),
      .gap_in    (gap[i]),
      .gap_out   (gap[i+1]),
      .hit_incr  (hit_incr[i]),
      .hit_final (hit_final[i]),
      .job_q     (job_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status;
      pop_valid_r   <= pop_hit;
      pop_kind_r    <= pop_hit ? job_q[0].kind : 2'd0;
      pop_session_r <= pop_hit ? job_q[0].session : 16'd0;
      pop_payload_r <= pop_hit ? job_q[0].payload : 32'd0;
      count_r       <= occ_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, (count_r == '0), count_r, pop_payload_r, pop_session_r,
                       pop_kind_r, pop_valid_r};

endmodule

### dv/tb_top.sv
module tb_top;
  import csjq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t                 status;
    logic                    pop_valid;
    job_kind_t               pop_kind;
    logic [SESSION_BITS-1:0] pop_session;
    logic [PAYLOAD_BITS-1:0] pop_payload;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
  } queue_result_t;

  // Mirrors the job row and holds the results still owed by the block.
  class coalesce_scoreboard;
    job_t          slots[DEPTH];
    int unsigned   fill;
    queue_result_t expected_results[$];
    int            errors;
    int            requests;
    int            popped;
    int            by_status[4];

    function new();
      fill = 0;
      errors = 0;
      requests = 0;
      popped = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function bit hits(job_t j, logic [SESSION_BITS-1:0] sess, bit incr, bit fin);
      return j.session == sess &&
             ((incr && j.kind == JOB_INCR) || (fin && j.kind == JOB_FINAL));
    endfunction

    function int unsigned count_hits(logic [SESSION_BITS-1:0] sess, bit incr, bit fin);
      int unsigned n;
      n = 0;
      for (int i = 0; i < fill; i++)
        if (hits(slots[i], sess, incr, fin)) n++;
      return n;
    endfunction

    function void purge(logic [SESSION_BITS-1:0] sess, bit incr, bit fin);
      int unsigned w;
      w = 0;
      for (int i = 0; i < fill; i++) begin
        if (!hits(slots[i], sess, incr, fin)) begin
          slots[w] = slots[i];
          w++;
        end
      end
      fill = w;
    endfunction

    // Room is judged after the push's own removals; a full queue leaves
    // everything untouched, removals included.
    function status_t append(job_t j, bit incr, bit fin);
      int unsigned freed;
      freed = count_hits(j.session, incr, fin);
      if (fill - freed >= DEPTH) return ST_FULL;
      purge(j.session, incr, fin);
      slots[fill] = j;
      fill++;
      return ST_DONE;
    endfunction

    function void note_request(logic [2:0] op, logic [SESSION_BITS-1:0] sess,
                               logic [PAYLOAD_BITS-1:0] data);
      queue_result_t r;
      job_t          j;
      r.status      = ST_DONE;
      r.pop_valid   = 1'b0;
      r.pop_kind    = JOB_INCR;
      r.pop_session = '0;
      r.pop_payload = '0;
      j.session     = sess;
      j.payload     = data;
      case (op)
        OP_PUSH_INCR: begin
          j.kind = JOB_INCR;
          if (count_hits(sess, 1'b0, 1'b1) != 0) r.status = ST_SUPPRESSED;
          else r.status = append(j, 1'b1, 1'b0);
        end
        OP_PUSH_FINAL: begin
          j.kind = JOB_FINAL;
          r.status = append(j, 1'b1, 1'b1);
        end
        OP_PUSH_MODEL: begin
          j.kind = JOB_MODEL;
          r.status = append(j, 1'b0, 1'b0);
        end
        OP_CANCEL: purge(sess, 1'b1, 1'b1);
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_POP_EMPTY;
          end else begin
            r.pop_valid   = 1'b1;
            r.pop_kind    = job_kind_t'(slots[0].kind);
            r.pop_session = slots[0].session;
            r.pop_payload = slots[0].payload;
            for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
            fill--;
            popped++;
          end
        end
        default: ;
      endcase
      r.count    = CNT_W'(fill);
      r.is_empty = (fill == 0);
      requests++;
      by_status[r.status]++;
      expected_results = {expected_results, r};
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [63:0] d);
      queue_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, expected nothing, actual status %0h data %h",
                 $time, st, d);
        errors++;
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      cmp("status", 64'(e.status), 64'(st));
      cmp("pop_valid", 64'(e.pop_valid), 64'(d[0]));
      cmp("pop_kind", 64'(e.pop_kind), 64'(d[2:1]));
      cmp("pop_session", 64'(e.pop_session), 64'(d[18:3]));
      cmp("pop_payload", 64'(e.pop_payload), 64'(d[50:19]));
      cmp("count", 64'(e.count), 64'(d[55:51]));
      cmp("is_empty", 64'(e.is_empty), 64'(d[56]));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // session[15:0], payload[47:16]
  logic [2:0]  in_tuser;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // pop_valid[0], pop_kind[2:1], pop_session[18:3],
                           // pop_payload[50:19], count[55:51], is_empty[56]
  logic [1:0]  out_tuser;  // status[1:0]

  bit tx_quiet;
  bit rx_quiet;

  coalesce_scoreboard sb = new();

  always #5 clk = ~clk;

  coalescing_session_job_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Results are checked before the request of the same edge is predicted;
  // a result never belongs to a request accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata[15:0], in_tdata[47:16]);
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [15:0] sess,
                              input logic [31:0] data);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, sess};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [15:0] pool[6];
    logic [2:0]  op;
    logic [15:0] sess;
    int          r;
    int          pop_pct;

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_POP, 16'h0000, 32'h0);
    send_request(OP_CANCEL, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(3'(OP_POP + 1), 16'h1234, $urandom);
    send_request(OP_PUSH_INCR, 16'h0000, 32'h0000_0000);
    // A second incremental of the same session replaces the first.
    send_request(OP_PUSH_INCR, 16'h0000, 32'hFFFF_FFFF);
    send_request(OP_PUSH_FINAL, 16'hFFFF, 32'hA5A5_5A5A);
    send_request(OP_PUSH_INCR, 16'hFFFF, 32'h1111_1111);
    send_request(OP_PUSH_FINAL, 16'h0000, 32'h5A5A_A5A5);
    send_request(OP_PUSH_MODEL, 16'h0000, 32'h0000_0001);
    send_request(OP_PUSH_MODEL, 16'h0000, 32'h8000_0000);
    send_request(OP_CANCEL, 16'h0000, 32'h0);
    for (int i = 1; i <= 13; i++) send_request(OP_PUSH_INCR, 16'(i), $urandom);
    // The queue is full now.
    send_request(OP_PUSH_MODEL, 16'h0000, $urandom);
    send_request(OP_PUSH_FINAL, 16'h0014, $urandom);
    send_request(OP_PUSH_INCR, 16'hFFFF, $urandom);
    send_request(OP_PUSH_INCR, 16'h0002, $urandom);
    send_request(OP_PUSH_FINAL, 16'h0001, $urandom);
    send_request(OP_CANCEL, 16'h0003, $urandom);
    send_request(OP_POP, 16'h0000, $urandom);

    // Alternate filling and draining phases over a small set of live sessions.
    for (int phase = 0; phase < 8; phase++) begin
      tx_quiet = (phase % 4 == 1) || (phase % 4 == 3);
      rx_quiet = (phase % 4 == 2) || (phase % 4 == 3);
      pop_pct  = (phase % 2 == 0) ? 15 : 55;
      foreach (pool[i]) pool[i] = 16'($urandom);
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = 3'(OP_POP + 1 + $urandom_range(0, 2));
        else if (r < 3 + pop_pct) op = OP_POP;
        else if (r < 13 + pop_pct) op = OP_CANCEL;
        else begin
          case ($urandom_range(0, 3))
            0, 1:    op = OP_PUSH_INCR;
            2:       op = OP_PUSH_FINAL;
            default: op = OP_PUSH_MODEL;
          endcase
        end
        sess = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, 5)];
        send_request(op, sess, $urandom);
      end
    end
    in_tvalid <= 1'b0;

    // One more edge so the last accepted request is on the books.
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Ran %0d requests with %0d jobs popped", sb.requests, sb.popped);
    $display("Outcomes: %0d done, %0d suppressed, %0d dropped full, %0d empty pops",
             sb.by_status[ST_DONE], sb.by_status[ST_SUPPRESSED],
             sb.by_status[ST_FULL], sb.by_status[ST_POP_EMPTY]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
